### rtl/ffpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpc_pkg
// Shared types and constants of the two-bucket flat-field correction block.
// ----------------------------------------------------------------------------
package ffpc_pkg;

	localparam int CFG_W       = 17;
	localparam int LEVEL_W     = 16;
	localparam int PIX_W       = 8;
	localparam int DIFF_W      = 18;
	localparam int PROD_W      = 35;
	localparam int NUM_W       = 32;
	localparam int DEN_W       = 16;
	localparam int DIV_STAGES  = NUM_W;
	localparam int SUM_W       = NUM_W + 2;
	// lane registers from table read to divider output
	localparam int LANE_LAT    = 3 + DIV_STAGES;
	localparam int FIRST_COLUMN = 1;
	localparam int FIRST_LINE   = 2;

	typedef enum logic {
		OP_LOAD    = 1'b0,
		OP_CORRECT = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		REG_CORRECT_ENABLE = 3'd0,
		REG_SIGNAL_MEAN_A  = 3'd1,
		REG_SIGNAL_MEAN_B  = 3'd2,
		REG_DARK_MEAN_A    = 3'd3,
		REG_DARK_MEAN_B    = 3'd4
	} reg_index_t;

	typedef struct packed {
		logic               operation;
		logic [7:0]         column;
		logic [7:0]         line;
		logic [PIX_W-1:0]   pixel_a;
		logic [PIX_W-1:0]   pixel_b;
		logic [LEVEL_W-1:0] dark_a;
		logic [LEVEL_W-1:0] light_a;
		logic [LEVEL_W-1:0] dark_b;
		logic [LEVEL_W-1:0] light_b;
	} cmd_t;

	typedef struct packed {
		logic [PIX_W-1:0] out_a;
		logic [PIX_W-1:0] out_b;
		logic             was_corrected;
	} res_t;

	// sideband that rides along with a quotient
	typedef struct packed {
		logic neg;
		logic eq;
	} div_tag_t;

endpackage

### rtl/ffpc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpc_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ffpc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4740,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic                 re,
	input  logic [AW-1:0]        raddr,
	output logic [WIDTH-1:0]     rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

### rtl/ffpc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpc_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ffpc_div (
	input  logic                          clk,
	input  logic                          en,
	input  logic [ffpc_pkg::NUM_W-1:0]    num,
	input  logic [ffpc_pkg::DEN_W-1:0]    den,
	input  ffpc_pkg::div_tag_t            tag,
	output logic [ffpc_pkg::NUM_W-1:0]    quot,
	output ffpc_pkg::div_tag_t            tag_out
);
	localparam int NW = ffpc_pkg::NUM_W;
	localparam int DW = ffpc_pkg::DEN_W;
	localparam int NS = ffpc_pkg::DIV_STAGES;

	logic [DW-1:0]      rem_q [NS];
	logic [NW-1:0]      dvd_q [NS];
	logic [DW-1:0]      den_q [NS];
	ffpc_pkg::div_tag_t tag_q [NS];

	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic [DW-1:0]      r_in;
		logic [NW-1:0]      d_in;
		logic [DW-1:0]      n_in;
		ffpc_pkg::div_tag_t t_in;
		logic [DW:0]        trial;
		logic               ge;

		if (k == 0) begin : g_first
			assign r_in = '0;
			assign d_in = num;
			assign n_in = den;
			assign t_in = tag;
		end else begin : g_next
			assign r_in = rem_q[k-1];
			assign d_in = dvd_q[k-1];
			assign n_in = den_q[k-1];
			assign t_in = tag_q[k-1];
		end

		assign trial = {r_in, d_in[NW-1]};
		assign ge    = trial >= {1'b0, n_in};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= ge ? DW'(trial - {1'b0, n_in}) : trial[DW-1:0];
				// quotient bits shift in where dividend bits leave
				dvd_q[k] <= {d_in[NW-2:0], ge};
				den_q[k] <= n_in;
				tag_q[k] <= t_in;
			end
		end
	end

	assign quot    = dvd_q[NS-1];
	assign tag_out = tag_q[NS-1];
endmodule

### rtl/ffpc_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpc_lane
// One bucket: scaled difference, signed divide, offset and saturation.
// ----------------------------------------------------------------------------
module ffpc_lane (
	input  logic                               clk,
	input  logic                               en,
	input  logic [ffpc_pkg::PIX_W-1:0]         pix,
	input  logic [ffpc_pkg::LEVEL_W-1:0]       dark,
	input  logic [ffpc_pkg::LEVEL_W-1:0]       light,
	input  logic signed [ffpc_pkg::CFG_W-1:0]  sig,
	input  logic [ffpc_pkg::LEVEL_W-1:0]       dmean,
	output logic [ffpc_pkg::PIX_W-1:0]         res,
	output logic                               eq
);
	localparam int SW = ffpc_pkg::SUM_W;

	logic signed [ffpc_pkg::DIFF_W-1:0] diff_s2;
	logic signed [ffpc_pkg::CFG_W-1:0]  den_s2;
	logic                               eq_s2;
	logic signed [ffpc_pkg::PROD_W-1:0] num_s3;
	logic signed [ffpc_pkg::CFG_W-1:0]  den_s3;
	logic                               eq_s3;
	logic [ffpc_pkg::NUM_W-1:0]         anum_s4;
	logic [ffpc_pkg::DEN_W-1:0]         aden_s4;
	ffpc_pkg::div_tag_t                 tag_s4;
	logic [ffpc_pkg::NUM_W-1:0]         quot;
	ffpc_pkg::div_tag_t                 tag_out;
	logic signed [SW-1:0]               qs;
	logic signed [SW-1:0]               sum;

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s2 <= $signed({2'b00, pix, 8'h00}) - $signed({2'b00, dark});
			den_s2  <= $signed({1'b0, light}) - $signed({1'b0, dark});
			eq_s2   <= light == dark;

			num_s3  <= ffpc_pkg::PROD_W'(diff_s2) * ffpc_pkg::PROD_W'(sig);
			den_s3  <= den_s2;
			eq_s3   <= eq_s2;

			// magnitudes stay below 2^32 and 2^16
			anum_s4 <= num_s3[ffpc_pkg::PROD_W-1] ? ffpc_pkg::NUM_W'(-num_s3)
			                                       : num_s3[ffpc_pkg::NUM_W-1:0];
			aden_s4 <= den_s3[ffpc_pkg::CFG_W-1] ? ffpc_pkg::DEN_W'(-den_s3)
			                                      : den_s3[ffpc_pkg::DEN_W-1:0];
			tag_s4.neg <= num_s3[ffpc_pkg::PROD_W-1] ^ den_s3[ffpc_pkg::CFG_W-1];
			tag_s4.eq  <= eq_s3;
		end
	end

	ffpc_div u_div (
		.clk     (clk),
		.en      (en),
		.num     (anum_s4),
		.den     (aden_s4),
		.tag     (tag_s4),
		.quot    (quot),
		.tag_out (tag_out)
	);

	always_comb begin
		qs  = tag_out.neg ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
		sum = $signed({{(SW-ffpc_pkg::LEVEL_W){1'b0}}, dmean}) + qs;
		if (sum[SW-1]) begin
			res = '0;
		end else if (sum[SW-1:16] != '0) begin
			res = '1;
		end else begin
			res = sum[15:8];
		end
	end

	assign eq = tag_out.eq;
endmodule

### rtl/flat_field_pixel_correction.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flat_field_pixel_correction
// Two-point flat-field correction of two side-by-side 8-bit pixel streams.
// ----------------------------------------------------------------------------
//  channel | signals                       | moves
//  --------+-------------------------------+-------------------------------
//  cmd     | cmd_valid, cmd_ready, cmd     | load or correct item in
//  res     | res_valid, res_ready, res     | one result per correct item
//  cfg     | cfg_we, cfg_index, cfg_data   | register writes, no handshake
//
// One item per clock while no result is held; each result passes the table read,
// multiply, and the 32-stage divider in each lane before its output register.
// Load items write the tables and give no result.
// Whole pipeline advances together: a held result stalls cmd_ready.
// Tables are not cleared at reset.
// ----------------------------------------------------------------------------
module flat_field_pixel_correction #(
	parameter int WINDOW_COLUMNS = 79,
	parameter int WINDOW_ROWS    = 60
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cmd_valid,
	output logic                              cmd_ready,
	input  ffpc_pkg::cmd_t                    cmd,
	output logic                              res_valid,
	input  logic                              res_ready,
	output ffpc_pkg::res_t                    res,
	input  logic                              cfg_we,
	input  logic [2:0]                        cfg_index,
	input  logic [ffpc_pkg::CFG_W-1:0]        cfg_data
);
	localparam int DEPTH = WINDOW_COLUMNS * WINDOW_ROWS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LAT   = ffpc_pkg::LANE_LAT;
	localparam int LW    = ffpc_pkg::LEVEL_W;

	typedef struct packed {
		logic                       valid;
		logic                       win;
		logic [ffpc_pkg::PIX_W-1:0] pix_a;
		logic [ffpc_pkg::PIX_W-1:0] pix_b;
	} side_t;

	logic                              enable_q;
	logic signed [ffpc_pkg::CFG_W-1:0] sig_a_q;
	logic signed [ffpc_pkg::CFG_W-1:0] sig_b_q;
	logic [LW-1:0]                     dmean_a_q;
	logic [LW-1:0]                     dmean_b_q;

	logic        adv;
	logic        accept;
	logic        in_win;
	logic [7:0]  col_off;
	logic [7:0]  line_off;
	logic [15:0] idx_full;
	logic [AW-1:0] idx;

	side_t             side_s1;
	side_t             dl_q [LAT];
	logic [2*LW-1:0]   rd_a;
	logic [2*LW-1:0]   rd_b;
	logic [ffpc_pkg::PIX_W-1:0] res_a;
	logic [ffpc_pkg::PIX_W-1:0] res_b;
	logic              eq_a;
	logic              eq_b;
	logic              res_valid_q;
	ffpc_pkg::res_t    res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b0;
			sig_a_q   <= 17'sd256;
			sig_b_q   <= 17'sd256;
			dmean_a_q <= '0;
			dmean_b_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				ffpc_pkg::REG_CORRECT_ENABLE: enable_q  <= cfg_data[0];
				ffpc_pkg::REG_SIGNAL_MEAN_A:  sig_a_q   <= $signed(cfg_data);
				ffpc_pkg::REG_SIGNAL_MEAN_B:  sig_b_q   <= $signed(cfg_data);
				ffpc_pkg::REG_DARK_MEAN_A:    dmean_a_q <= cfg_data[LW-1:0];
				ffpc_pkg::REG_DARK_MEAN_B:    dmean_b_q <= cfg_data[LW-1:0];
				default: ;
			endcase
		end
	end

	assign adv       = !res_valid_q || res_ready;
	assign cmd_ready = adv;
	assign accept    = cmd_valid && adv;

	// window position and table address
	always_comb begin
		in_win = (cmd.column >= 8'(ffpc_pkg::FIRST_COLUMN))
		      && (9'(cmd.column) < 9'(ffpc_pkg::FIRST_COLUMN + WINDOW_COLUMNS))
		      && (cmd.line >= 8'(ffpc_pkg::FIRST_LINE))
		      && (9'(cmd.line) < 9'(ffpc_pkg::FIRST_LINE + WINDOW_ROWS));
		col_off  = cmd.column - 8'(ffpc_pkg::FIRST_COLUMN);
		line_off = cmd.line - 8'(ffpc_pkg::FIRST_LINE);
		idx_full = 16'(col_off) * 16'(WINDOW_ROWS) + 16'(line_off);
		idx      = idx_full[AW-1:0];
	end

	logic tbl_we;
	assign tbl_we = accept && (cmd.operation == ffpc_pkg::OP_LOAD) && in_win;

	ffpc_ram #(.WIDTH(2*LW), .DEPTH(DEPTH)) u_ram_a (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (idx),
		.wdata ({cmd.dark_a, cmd.light_a}),
		.re    (adv),
		.raddr (idx),
		.rdata (rd_a)
	);

	ffpc_ram #(.WIDTH(2*LW), .DEPTH(DEPTH)) u_ram_b (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (idx),
		.wdata ({cmd.dark_b, cmd.light_b}),
		.re    (adv),
		.raddr (idx),
		.rdata (rd_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
		end else if (adv) begin
			side_s1.valid <= accept && (cmd.operation == ffpc_pkg::OP_CORRECT);
			side_s1.win   <= in_win && enable_q;
			side_s1.pix_a <= cmd.pixel_a;
			side_s1.pix_b <= cmd.pixel_b;
		end
	end

	ffpc_lane u_lane_a (
		.clk   (clk),
		.en    (adv),
		.pix   (side_s1.pix_a),
		.dark  (rd_a[2*LW-1:LW]),
		.light (rd_a[LW-1:0]),
		.sig   (sig_a_q),
		.dmean (dmean_a_q),
		.res   (res_a),
		.eq    (eq_a)
	);

	ffpc_lane u_lane_b (
		.clk   (clk),
		.en    (adv),
		.pix   (side_s1.pix_b),
		.dark  (rd_b[2*LW-1:LW]),
		.light (rd_b[LW-1:0]),
		.sig   (sig_b_q),
		.dmean (dmean_b_q),
		.res   (res_b),
		.eq    (eq_b)
	);

	// pass-through data and valid follow the lanes
	for (genvar k = 0; k < LAT; k++) begin : g_dl
		side_t src;
		if (k == 0) begin : g_first
			assign src = side_s1;
		end else begin : g_next
			assign src = dl_q[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dl_q[k] <= '0;
			end else if (adv) begin
				dl_q[k] <= src;
			end
		end
	end

	// merge: both buckets must have distinct levels to correct
	logic do_corr;
	assign do_corr = dl_q[LAT-1].win && !eq_a && !eq_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= dl_q[LAT-1].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q.out_a         <= do_corr ? res_a : dl_q[LAT-1].pix_a;
			res_q.out_b         <= do_corr ? res_b : dl_q[LAT-1].pix_b;
			res_q.was_corrected <= do_corr;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_corr_needs_enable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.was_corrected |-> enable_q)
		else $error("corrected item while correction disabled");

	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd.operation == ffpc_pkg::OP_LOAD |=> !side_s1.valid)
		else $error("load item entered result pipeline");

	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !$past(res_valid_q) |-> $past(dl_q[LAT-1].valid))
		else $error("result appeared without a tracked item");
endmodule
